>>> design/adsu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the advertising service UUID128 filter.
package adsu_pkg;

    localparam int UUID_BYTES = 16;
    localparam int CHUNK_W    = $clog2(UUID_BYTES);
    localparam int UUID_W     = 8 * UUID_BYTES;
    localparam int CFG_W      = 64;

    localparam logic [7:0] AD_TYPE_UUID128_PART = 8'h06;
    localparam logic [7:0] AD_TYPE_UUID128_FULL = 8'h07;

    typedef enum logic {
        REG_UUID_LOW  = 1'b0,
        REG_UUID_HIGH = 1'b1
    } t_cfg_index;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_END  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_FOUND     = 2'd1,
        ST_OVERRUN   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_BODY = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       advance;
        logic       req_end;
        logic [7:0] data;
    } t_parse_ctl;

endpackage

>>> design/ad_service_uuid128_filter.sv
`timescale 1ns / 1ps
// Top level of the advertising service UUID128 filter.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_req_type, i_ad_byte
//   result   out        o_valid / i_stall    o_match_status
//   config   in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
// One item per cycle while o_stall is low; an item passes an input register, one pass of
// parse logic, then the result register.
// Data items yield no result and never wait on the result side.
// An end item waits in the input register only while a held result is stalled.
// Reset clears the valid bits of both registers and all parse state; no clearing pass.
module ad_service_uuid128_filter import adsu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_req_type,
    input  logic [7:0]       i_ad_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_match_status
);

    logic       r_in_valid;
    logic       r_req_type;
    logic [7:0] r_ad_byte;
    logic       r_out_valid;
    t_status    r_status;

    logic       out_free;
    logic       advance;
    logic       in_take;
    t_parse_ctl ctl;
    t_status    status;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (t_req_type'(r_req_type) == REQ_DATA || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    assign ctl.advance = advance;
    assign ctl.req_end = (t_req_type'(r_req_type) == REQ_END);
    assign ctl.data    = r_ad_byte;

    adsu_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (ctl),
        .o_status    (status)
    );

    // hold the input item until the parse pass takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type <= i_req_type;
            r_ad_byte  <= i_ad_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && ctl.req_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ctl.req_end) begin
            r_status <= status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_match_status = r_status;

endmodule

>>> design/adsu_parse.sv
`timescale 1ns / 1ps
// Length-type-value walker and UUID chunk compare for one registered item.
module adsu_parse import adsu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_parse_ctl       i_ctl,
    output t_status          o_status
);

    logic [CFG_W-1:0]   r_uuid_low;
    logic [CFG_W-1:0]   r_uuid_high;
    t_phase             r_phase,      n_phase;
    logic [7:0]         r_bytes_left, n_bytes_left;
    logic               r_cand,       n_cand;
    logic [CHUNK_W-1:0] r_chunk_idx,  n_chunk_idx;
    logic               r_chunk_eq,   n_chunk_eq;
    logic               r_hit,        n_hit;
    logic               r_found,      n_found;

    logic [UUID_W-1:0]  uuid;
    logic [7:0]         uuid_byte;
    logic [7:0]         left_dec;
    logic               byte_eq;
    logic               hit_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid_low  <= '0;
            r_uuid_high <= '0;
        end else if (i_cfg_we) begin
            if (t_cfg_index'(i_cfg_index) == REG_UUID_LOW) begin
                r_uuid_low <= i_cfg_wdata;
            end else begin
                r_uuid_high <= i_cfg_wdata;
            end
        end
    end

    assign uuid      = {r_uuid_high, r_uuid_low};
    assign uuid_byte = uuid[{r_chunk_idx, 3'b000} +: 8];
    assign left_dec  = r_bytes_left - 8'd1;
    assign byte_eq   = r_chunk_eq && (i_ctl.data == uuid_byte);
    assign hit_now   = r_hit || byte_eq;

    always_comb begin
        if (r_found) begin
            o_status = ST_FOUND;
        end else if (r_phase == PH_TYPE || r_phase == PH_BODY) begin
            o_status = ST_OVERRUN;
        end else begin
            o_status = ST_NOT_FOUND;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_cand       = r_cand;
        n_chunk_idx  = r_chunk_idx;
        n_chunk_eq   = r_chunk_eq;
        n_hit        = r_hit;
        n_found      = r_found;
        if (i_ctl.req_end) begin
            n_phase      = PH_LEN;
            n_bytes_left = '0;
            n_cand       = 1'b0;
            n_chunk_idx  = '0;
            n_chunk_eq   = 1'b1;
            n_hit        = 1'b0;
            n_found      = 1'b0;
        end else begin
            unique case (r_phase)
                PH_LEN: begin
                    if (i_ctl.data == 8'd0) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_bytes_left = i_ctl.data;
                        n_phase      = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_bytes_left = left_dec;
                    n_cand       = (i_ctl.data == AD_TYPE_UUID128_PART ||
                                    i_ctl.data == AD_TYPE_UUID128_FULL) &&
                                   (left_dec[CHUNK_W-1:0] == '0);
                    n_chunk_idx  = '0;
                    n_chunk_eq   = 1'b1;
                    n_hit        = 1'b0;
                    n_phase      = (left_dec == 8'd0) ? PH_LEN : PH_BODY;
                end
                PH_BODY: begin
                    if (r_cand) begin
                        if (r_chunk_idx == CHUNK_W'(UUID_BYTES - 1)) begin
                            n_hit       = hit_now;
                            n_chunk_idx = '0;
                            n_chunk_eq  = 1'b1;
                        end else begin
                            n_chunk_idx = r_chunk_idx + CHUNK_W'(1);
                            n_chunk_eq  = byte_eq;
                        end
                    end
                    n_bytes_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_found = r_found || n_hit;
                        n_phase = PH_LEN;
                    end
                end
                PH_STOP: begin
                    n_phase = PH_STOP;
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_bytes_left <= '0;
            r_cand       <= 1'b0;
            r_chunk_idx  <= '0;
            r_chunk_eq   <= 1'b1;
            r_hit        <= 1'b0;
            r_found      <= 1'b0;
        end else if (i_ctl.advance) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_cand       <= n_cand;
            r_chunk_idx  <= n_chunk_idx;
            r_chunk_eq   <= n_chunk_eq;
            r_hit        <= n_hit;
            r_found      <= n_found;
        end
    end

endmodule

>>> design/adsu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the UUID128 filter, bound to the top level.
module adsu_checker import adsu_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_req_type,
    input logic [7:0]       i_ad_byte,
    input logic             o_valid,
    input logic             i_stall,
    input logic [1:0]       o_match_status
);

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_reset_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match_status == ST_NOT_FOUND || o_match_status == ST_FOUND ||
                     o_match_status == ST_OVERRUN))
        else $error("result status outside its codes");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_match_status))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_req_type) && $stable(i_ad_byte))
        else $error("stalled input item changed");

endmodule

bind ad_service_uuid128_filter adsu_checker u_adsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_req_type     (i_req_type),
    .i_ad_byte      (i_ad_byte),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_match_status (o_match_status)
);
